// ===== rtl/core/rts_pkg.sv =====
// ----------------------------------------------------------------------------
// rts_pkg
// Shared types, codes and helpers for the i2c register transfer sequencer.
// ----------------------------------------------------------------------------
package rts_pkg;

    // payload store geometry
    localparam int PAYLOAD_DEPTH = 256;
    localparam int PAYLOAD_AW    = $clog2(PAYLOAD_DEPTH);

    // retry budget after reset
    localparam logic [7:0] RESTARTS_RESET = 8'd20;

    // command codes of an input item
    typedef enum logic [1:0] {
        CMD_LOAD   = 2'd0,
        CMD_WRITE  = 2'd1,
        CMD_READ   = 2'd2,
        CMD_FINISH = 2'd3
    } cmd_t;

    // bus operation codes
    typedef enum logic [2:0] {
        OP_NONE   = 3'd0,
        OP_START  = 3'd1,
        OP_STOP   = 3'd2,
        OP_SEND   = 3'd3,
        OP_RXACK  = 3'd4,
        OP_RXNACK = 3'd5
    } bus_op_t;

    // transfer result codes
    typedef enum logic [2:0] {
        RES_OK         = 3'd0,
        RES_START_FAIL = 3'd1,
        RES_ADDR_NACK  = 3'd2,
        RES_REG_NACK   = 3'd3,
        RES_DATA_FAIL  = 3'd4,
        RES_RADDR_NACK = 3'd5
    } res_code_t;

    // bus engine status codes, low three bits masked
    localparam logic [4:0] ST_START   = 5'h01;
    localparam logic [4:0] ST_RSTART  = 5'h02;
    localparam logic [4:0] ST_SLAW_AK = 5'h03;
    localparam logic [4:0] ST_DATA_AK = 5'h05;
    localparam logic [4:0] ST_SLAR_AK = 5'h08;
    localparam logic [4:0] ST_RX_AK   = 5'h0A;

    // result of the sequencer before the payload read returns
    typedef struct packed {
        logic [2:0] bus_op;
        logic [7:0] op_byte;
        logic       mem_sel;
        logic       read_valid;
        logic [7:0] read_data;
        logic [7:0] read_index;
        logic       done_res;
        logic [2:0] result_code;
    } rts_s1_t;

    function automatic logic start_ok(input logic [7:0] st);
        logic [4:0] s;
        s = st[7:3];
        return (s == ST_START) || (s == ST_RSTART);
    endfunction

    function automatic logic ack_ok(input logic [7:0] st);
        logic [4:0] s;
        s = st[7:3];
        return (s == ST_SLAW_AK) || (s == ST_DATA_AK) || (s == ST_SLAR_AK) || (s == ST_RX_AK);
    endfunction

    function automatic logic pos_in_range(input logic [7:0] pos);
        return {1'b0, pos} < 9'(PAYLOAD_DEPTH);
    endfunction

endpackage

// ===== rtl/core/rts_if.sv =====
// ----------------------------------------------------------------------------
// rts_if
// Valid/ready channels for sequencer command items and result items.
// ----------------------------------------------------------------------------
interface rts_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] cmd;
    logic [6:0] device_addr;
    logic [7:0] reg_addr;
    logic [7:0] length;
    logic [7:0] buf_index;
    logic [7:0] tx_byte;
    logic [7:0] bus_status;
    logic [7:0] rx_byte;

    modport source (
        output valid, cmd, device_addr, reg_addr, length, buf_index, tx_byte,
               bus_status, rx_byte,
        input  ready
    );
    modport sink (
        input  valid, cmd, device_addr, reg_addr, length, buf_index, tx_byte,
               bus_status, rx_byte,
        output ready
    );
endinterface

interface rts_out_if;
    logic       valid;
    logic       ready;
    logic [2:0] bus_op;
    logic [7:0] op_byte;
    logic       read_valid;
    logic [7:0] read_data;
    logic [7:0] read_index;
    logic       done_res;
    logic [2:0] result_code;

    modport source (
        output valid, bus_op, op_byte, read_valid, read_data, read_index, done_res,
               result_code,
        input  ready
    );
    modport sink (
        input  valid, bus_op, op_byte, read_valid, read_data, read_index, done_res,
               result_code,
        output ready
    );
endinterface

// ===== rtl/core/i2c_register_transfer_sequencer_unit.sv =====
// ----------------------------------------------------------------------------
// i2c_register_transfer_sequencer_unit
// I2C master register read/write sequencer driving a byte-level bus engine.
// ----------------------------------------------------------------------------
// pipeline: an accepted command item is held in the s1 register, then its result
//   item moves to the output register, where it is valid
// throughput: one item per cycle while the receiver takes result items; the payload
//   store read of a send is registered and is absorbed by the result pipeline
// reset: phase idle, counters zero, retry budget 20, result pipeline empty;
//   the payload store is not cleared
module i2c_register_transfer_sequencer_unit (
    input  logic      clk,
    input  logic      rst_n,
    rts_in_if.sink    req,
    rts_out_if.source rsp,
    input  logic      cfg_we,
    input  logic [7:0] cfg_wdata
);
    import rts_pkg::*;

    logic                  accept;
    logic                  free;
    logic                  load_we;
    rts_s1_t               s1;
    logic [PAYLOAD_AW-1:0] mem_raddr;
    logic [7:0]            mem_rdata;

    assign req.ready = free;
    assign accept    = req.valid && free;
    assign load_we   = accept && (cmd_t'(req.cmd) == CMD_LOAD) && pos_in_range(req.buf_index);

    // payload store
    rts_payload_mem u_mem (
        .clk   (clk),
        .we    (load_we),
        .waddr (req.buf_index[PAYLOAD_AW-1:0]),
        .wdata (req.tx_byte),
        .re    (accept),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // transfer sequencer
    rts_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .cmd         (req.cmd),
        .device_addr (req.device_addr),
        .reg_addr    (req.reg_addr),
        .length      (req.length),
        .bus_status  (req.bus_status),
        .rx_byte     (req.rx_byte),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .s1          (s1),
        .mem_raddr   (mem_raddr)
    );

    // result pipeline
    rts_out u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (accept),
        .s1_in     (s1),
        .mem_rdata (mem_rdata),
        .free      (free),
        .rsp       (rsp)
    );

endmodule

// ===== rtl/core/rts_payload_mem.sv =====
// ----------------------------------------------------------------------------
// rts_payload_mem
// Payload byte store: one write port, one registered read port.
// ----------------------------------------------------------------------------
module rts_payload_mem (
    input  logic                          clk,
    input  logic                          we,
    input  logic [rts_pkg::PAYLOAD_AW-1:0] waddr,
    input  logic [7:0]                    wdata,
    input  logic                          re,
    input  logic [rts_pkg::PAYLOAD_AW-1:0] raddr,
    output logic [7:0]                    rdata
);
    import rts_pkg::*;

    logic [7:0] mem [PAYLOAD_DEPTH];
    logic [7:0] rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // read port, data held until the next read
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/core/rts_ctrl.sv =====
// ----------------------------------------------------------------------------
// rts_ctrl
// Transfer sequencer: phase, retry budget and byte counters, one item a cycle while accepted.
// ----------------------------------------------------------------------------
module rts_ctrl (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           accept,
    input  logic [1:0]                     cmd,
    input  logic [6:0]                     device_addr,
    input  logic [7:0]                     reg_addr,
    input  logic [7:0]                     length,
    input  logic [7:0]                     bus_status,
    input  logic [7:0]                     rx_byte,
    input  logic                           cfg_we,
    input  logic [7:0]                     cfg_wdata,
    output rts_pkg::rts_s1_t               s1,
    output logic [rts_pkg::PAYLOAD_AW-1:0] mem_raddr
);
    import rts_pkg::*;

    typedef enum logic [3:0] {
        PH_IDLE     = 4'd0,
        PH_W_START  = 4'd1,
        PH_W_SLA    = 4'd2,
        PH_W_REG    = 4'd3,
        PH_W_DATA   = 4'd4,
        PH_R_START  = 4'd5,
        PH_R_SLA    = 4'd6,
        PH_R_REG    = 4'd7,
        PH_R_RSTART = 4'd8,
        PH_R_SLAR   = 4'd9,
        PH_R_DATA   = 4'd10
    } phase_t;

    phase_t     phase_reg,   phase_next;
    logic [7:0] retries_reg, retries_next;
    logic [7:0] bytes_reg,   bytes_next;
    logic [7:0] pos_reg,     pos_next;
    logic [6:0] taddr_reg,   taddr_next;
    logic [7:0] treg_reg,    treg_next;
    logic [7:0] max_restarts_reg;
    logic [7:0] retries_dec;
    logic [7:0] bytes_dec;
    logic       st_start;
    logic       st_ack;

    assign retries_dec = retries_reg - 8'd1;
    assign bytes_dec   = bytes_reg - 8'd1;
    assign st_start    = start_ok(bus_status);
    assign st_ack      = ack_ok(bus_status);
    assign mem_raddr   = pos_reg[PAYLOAD_AW-1:0];

    // next state and result of the accepted item
    always_comb
    begin
        phase_next   = phase_reg;
        retries_next = retries_reg;
        bytes_next   = bytes_reg;
        pos_next     = pos_reg;
        taddr_next   = taddr_reg;
        treg_next    = treg_reg;
        s1           = '0;

        unique case (cmd_t'(cmd)) inside
            CMD_LOAD:
            begin
                // store write handled by the payload memory
            end
            CMD_WRITE, CMD_READ:
            begin
                if (phase_reg == PH_IDLE)
                begin
                    if (length == 8'd0)
                    begin
                        s1.done_res    = 1'b1;
                        s1.result_code = RES_OK;
                    end
                    else
                    begin
                        taddr_next   = device_addr;
                        treg_next    = reg_addr;
                        bytes_next   = length;
                        pos_next     = 8'd0;
                        retries_next = max_restarts_reg;
                        phase_next   = (cmd_t'(cmd) == CMD_READ) ? PH_R_START : PH_W_START;
                        s1.bus_op    = OP_START;
                    end
                end
            end
            CMD_FINISH:
            begin
                unique case (phase_reg) inside
                    PH_W_START, PH_W_SLA:
                    begin
                        if ((phase_reg == PH_W_START) ? st_start : st_ack)
                        begin
                            phase_next = (phase_reg == PH_W_START) ? PH_W_SLA : PH_W_REG;
                            s1.bus_op  = OP_SEND;
                            s1.op_byte = (phase_reg == PH_W_START) ? {taddr_reg, 1'b0}
                                                                   : treg_reg;
                        end
                        else if (retries_reg == 8'd0)
                        begin
                            // budget spent: stop and report
                            phase_next     = PH_IDLE;
                            s1.bus_op      = OP_STOP;
                            s1.done_res    = 1'b1;
                            s1.result_code = (phase_reg == PH_W_START) ? RES_START_FAIL
                                                                       : RES_ADDR_NACK;
                        end
                        else
                        begin
                            retries_next = retries_dec;
                            phase_next   = PH_W_START;
                            s1.bus_op    = OP_START;
                        end
                    end
                    PH_W_REG, PH_W_DATA:
                    begin
                        if (!st_ack)
                        begin
                            phase_next     = PH_IDLE;
                            s1.done_res    = 1'b1;
                            s1.result_code = (phase_reg == PH_W_REG) ? RES_REG_NACK
                                                                     : RES_DATA_FAIL;
                        end
                        else if (phase_reg == PH_W_DATA && bytes_dec == 8'd0)
                        begin
                            bytes_next     = bytes_dec;
                            phase_next     = PH_IDLE;
                            s1.bus_op      = OP_STOP;
                            s1.done_res    = 1'b1;
                            s1.result_code = RES_OK;
                        end
                        else
                        begin
                            // send next payload byte, read from the store
                            if (phase_reg == PH_W_DATA)
                            begin
                                bytes_next = bytes_dec;
                            end
                            phase_next = PH_W_DATA;
                            s1.bus_op  = OP_SEND;
                            s1.mem_sel = pos_in_range(pos_reg);
                            pos_next   = pos_reg + 8'd1;
                        end
                    end
                    PH_R_START, PH_R_SLA:
                    begin
                        if ((phase_reg == PH_R_START) ? st_start : st_ack)
                        begin
                            phase_next = (phase_reg == PH_R_START) ? PH_R_SLA : PH_R_REG;
                            s1.bus_op  = OP_SEND;
                            s1.op_byte = (phase_reg == PH_R_START) ? {taddr_reg, 1'b0}
                                                                   : treg_reg;
                        end
                        else
                        begin
                            // budget drops first, wrapping from zero
                            retries_next = retries_dec;
                            if (retries_dec == 8'd0)
                            begin
                                phase_next     = PH_IDLE;
                                s1.done_res    = 1'b1;
                                s1.bus_op      = (phase_reg == PH_R_START) ? OP_NONE : OP_STOP;
                                s1.result_code = (phase_reg == PH_R_START) ? RES_START_FAIL
                                                                           : RES_ADDR_NACK;
                            end
                            else
                            begin
                                phase_next = PH_R_START;
                                s1.bus_op  = OP_START;
                            end
                        end
                    end
                    PH_R_REG:
                    begin
                        if (st_ack)
                        begin
                            phase_next = PH_R_RSTART;
                            s1.bus_op  = OP_START;
                        end
                        else
                        begin
                            phase_next     = PH_IDLE;
                            s1.done_res    = 1'b1;
                            s1.result_code = RES_REG_NACK;
                        end
                    end
                    PH_R_RSTART:
                    begin
                        if (st_start)
                        begin
                            phase_next = PH_R_SLAR;
                            s1.bus_op  = OP_SEND;
                            s1.op_byte = {taddr_reg, 1'b1};
                        end
                        else
                        begin
                            phase_next     = PH_IDLE;
                            s1.done_res    = 1'b1;
                            s1.result_code = RES_DATA_FAIL;
                        end
                    end
                    PH_R_SLAR:
                    begin
                        if (st_ack)
                        begin
                            phase_next = PH_R_DATA;
                            s1.bus_op  = (bytes_reg > 8'd1) ? OP_RXACK : OP_RXNACK;
                        end
                        else
                        begin
                            phase_next     = PH_IDLE;
                            s1.done_res    = 1'b1;
                            s1.result_code = RES_RADDR_NACK;
                        end
                    end
                    PH_R_DATA:
                    begin
                        s1.read_valid = 1'b1;
                        s1.read_data  = rx_byte;
                        s1.read_index = pos_reg;
                        pos_next      = pos_reg + 8'd1;
                        bytes_next    = bytes_dec;
                        if (bytes_dec == 8'd0)
                        begin
                            phase_next     = PH_IDLE;
                            s1.bus_op      = OP_STOP;
                            s1.done_res    = 1'b1;
                            s1.result_code = RES_OK;
                        end
                        else
                        begin
                            s1.bus_op = (bytes_dec > 8'd1) ? OP_RXACK : OP_RXNACK;
                        end
                    end
                    default:
                    begin
                        // finish while idle: no effect
                    end
                endcase
            end
            default:
            begin
            end
        endcase
    end

    // sequencer state and retry budget register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= PH_IDLE;
            retries_reg      <= '0;
            bytes_reg        <= '0;
            pos_reg          <= '0;
            taddr_reg        <= '0;
            treg_reg         <= '0;
            max_restarts_reg <= RESTARTS_RESET;
        end
        else
        begin
            if (accept)
            begin
                phase_reg   <= phase_next;
                retries_reg <= retries_next;
                bytes_reg   <= bytes_next;
                pos_reg     <= pos_next;
                taddr_reg   <= taddr_next;
                treg_reg    <= treg_next;
            end
            if (cfg_we)
            begin
                max_restarts_reg <= cfg_wdata;
            end
        end
    end

endmodule

// ===== rtl/core/rts_out.sv =====
// ----------------------------------------------------------------------------
// rts_out
// Result pipeline: joins store read data to the result, then output register.
// ----------------------------------------------------------------------------
module rts_out (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             load,
    input  rts_pkg::rts_s1_t s1_in,
    input  logic [7:0]       mem_rdata,
    output logic             free,
    rts_out_if.source        rsp
);
    import rts_pkg::*;

    logic       s1_valid_reg;
    rts_s1_t    s1_reg;
    logic       out_valid_reg;
    logic [2:0] bus_op_reg;
    logic [7:0] op_byte_reg;
    logic       read_valid_reg;
    logic [7:0] read_data_reg;
    logic [7:0] read_index_reg;
    logic       done_res_reg;
    logic [2:0] result_code_reg;
    logic       advance;

    assign advance = s1_valid_reg && (!out_valid_reg || rsp.ready);
    assign free    = !s1_valid_reg || advance;

    // stage valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                s1_valid_reg <= 1'b0;
            end

            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload of both stages
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            s1_reg <= s1_in;
        end
        if (advance)
        begin
            bus_op_reg      <= s1_reg.bus_op;
            op_byte_reg     <= s1_reg.mem_sel ? mem_rdata : s1_reg.op_byte;
            read_valid_reg  <= s1_reg.read_valid;
            read_data_reg   <= s1_reg.read_data;
            read_index_reg  <= s1_reg.read_index;
            done_res_reg    <= s1_reg.done_res;
            result_code_reg <= s1_reg.result_code;
        end
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.bus_op      = bus_op_reg;
    assign rsp.op_byte     = op_byte_reg;
    assign rsp.read_valid  = read_valid_reg;
    assign rsp.read_data   = read_data_reg;
    assign rsp.read_index  = read_index_reg;
    assign rsp.done_res    = done_res_reg;
    assign rsp.result_code = result_code_reg;

endmodule

// ===== rtl/core/rts_chk.sv =====
// ----------------------------------------------------------------------------
// rts_chk
// Port-level checks of the sequencer result items.
// ----------------------------------------------------------------------------
module rts_chk (
    input logic       clk,
    input logic       rst_n,
    input logic       rsp_valid,
    input logic       rsp_ready,
    input logic [2:0] bus_op,
    input logic [7:0] op_byte,
    input logic       read_valid,
    input logic [7:0] read_data,
    input logic [7:0] read_index,
    input logic       done_res,
    input logic [2:0] result_code
);
    import rts_pkg::*;

    // stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(bus_op) && $stable(op_byte)
            && $stable(done_res) && $stable(result_code))
        else $error("result item changed while stalled");

    // result code only with an ended transfer
    a_code: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !done_res |-> result_code == RES_OK)
        else $error("result code without done");

    // a byte only with a send
    a_byte: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && bus_op != OP_SEND |-> op_byte == 8'd0)
        else $error("op byte without send");

    // received data only in the receive phase
    a_rx: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && read_valid |-> bus_op == OP_RXACK || bus_op == OP_RXNACK
            || bus_op == OP_STOP)
        else $error("read data with unexpected bus operation");

    // idle read fields are zero
    a_rx0: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !read_valid |-> read_data == 8'd0 && read_index == 8'd0)
        else $error("read fields set without read valid");

endmodule

bind i2c_register_transfer_sequencer_unit rts_chk u_chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .rsp_valid   (rsp.valid),
    .rsp_ready   (rsp.ready),
    .bus_op      (rsp.bus_op),
    .op_byte     (rsp.op_byte),
    .read_valid  (rsp.read_valid),
    .read_data   (rsp.read_data),
    .read_index  (rsp.read_index),
    .done_res    (rsp.done_res),
    .result_code (rsp.result_code)
);

// ===== test/i2c_register_transfer_sequencer_unit_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// i2c_register_transfer_sequencer_unit_test
// Drives whole register write and read transfers into the sequencer. A small
// bus engine model answers each bus operation with good or failing status,
// and a transfer model predicts one result item per command item. Sender gaps,
// receiver stalls and retry budget changes between phases are included.
// ----------------------------------------------------------------------------
module i2c_register_transfer_sequencer_unit_test;
    import rts_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int LATENCY_PAUSE  = 4;

    localparam logic [7:0] START_CODES [2] = '{8'h08, 8'h10};
    localparam logic [7:0] ACK_CODES   [4] = '{8'h18, 8'h28, 8'h40, 8'h50};

    // transfer sequence position
    typedef enum logic [3:0] {
        XS_IDLE,
        XS_W_START,
        XS_W_ADDR,
        XS_W_REG,
        XS_W_DATA,
        XS_R_START,
        XS_R_ADDR,
        XS_R_REG,
        XS_R_RSTART,
        XS_R_ADDR_RD,
        XS_R_DATA
    } xfer_state_t;

    typedef struct packed {
        cmd_t       cmd;
        logic [6:0] device_addr;
        logic [7:0] reg_addr;
        logic [7:0] length;
        logic [7:0] buf_index;
        logic [7:0] tx_byte;
        logic [7:0] bus_status;
        logic [7:0] rx_byte;
    } seq_cmd_t;

    typedef struct packed {
        bus_op_t    bus_op;
        logic [7:0] op_byte;
        logic       read_valid;
        logic [7:0] read_data;
        logic [7:0] read_index;
        logic       done_res;
        res_code_t  result_code;
    } seq_result_t;

    // transfer model plus queue of expected result items
    class xfer_scoreboard;
        xfer_state_t xs;
        logic [7:0]  budget;
        logic [7:0]  retries_left;
        logic [7:0]  bytes_left;
        logic [7:0]  byte_pos;
        logic [6:0]  target_addr;
        logic [7:0]  target_reg;
        logic [7:0]  payload [PAYLOAD_DEPTH];
        seq_result_t expected_q [$];
        seq_result_t res;
        bit          ignored;
        int          errors;

        function new();
            xs           = XS_IDLE;
            budget       = RESTARTS_RESET;
            retries_left = '0;
            bytes_left   = '0;
            byte_pos     = '0;
            target_addr  = '0;
            target_reg   = '0;
            errors       = 0;
        endfunction

        function bit status_is_start(logic [7:0] st);
            logic [7:0] m;
            m = st & 8'hF8;
            return (m == 8'h08) || (m == 8'h10);
        endfunction

        function bit status_is_ack(logic [7:0] st);
            logic [7:0] m;
            m = st & 8'hF8;
            return (m == 8'h18) || (m == 8'h28) || (m == 8'h40) || (m == 8'h50);
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function void issue(bus_op_t op, logic [7:0] b);
            res.bus_op  = op;
            res.op_byte = b;
        endfunction

        function void end_xfer(bus_op_t op, res_code_t code);
            res.bus_op      = op;
            res.done_res    = 1'b1;
            res.result_code = code;
            xs              = XS_IDLE;
        endfunction

        // write side gives up once the budget is already zero
        function void retry_write(res_code_t code);
            if (retries_left == 0)
            begin
                end_xfer(OP_STOP, code);
            end
            else
            begin
                retries_left = retries_left - 8'd1;
                xs = XS_W_START;
                issue(OP_START, 8'h00);
            end
        endfunction

        // read side decrements first, so a zero budget wraps to 256 tries
        function void retry_read(res_code_t code, bus_op_t last_op);
            retries_left = retries_left - 8'd1;
            if (retries_left == 0)
            begin
                end_xfer(last_op, code);
            end
            else
            begin
                xs = XS_R_START;
                issue(OP_START, 8'h00);
            end
        endfunction

        function logic [7:0] next_payload();
            logic [7:0] b;
            b = (byte_pos < PAYLOAD_DEPTH) ? payload[byte_pos] : 8'h00;
            byte_pos = byte_pos + 8'd1;
            return b;
        endfunction

        function bus_op_t receive_op();
            if (bytes_left > 8'd1)
            begin
                return OP_RXACK;
            end
            return OP_RXNACK;
        endfunction

        // one finished bus operation
        function void bus_done(logic [7:0] st, logic [7:0] rx);
            case (xs)
                XS_W_START:
                    if (status_is_start(st))
                    begin
                        xs = XS_W_ADDR;
                        issue(OP_SEND, {target_addr, 1'b0});
                    end
                    else retry_write(RES_START_FAIL);
                XS_W_ADDR:
                    if (status_is_ack(st))
                    begin
                        xs = XS_W_REG;
                        issue(OP_SEND, target_reg);
                    end
                    else retry_write(RES_ADDR_NACK);
                XS_W_REG:
                    if (!status_is_ack(st)) end_xfer(OP_NONE, RES_REG_NACK);
                    else
                    begin
                        xs = XS_W_DATA;
                        issue(OP_SEND, next_payload());
                    end
                XS_W_DATA:
                    if (!status_is_ack(st)) end_xfer(OP_NONE, RES_DATA_FAIL);
                    else
                    begin
                        bytes_left = bytes_left - 8'd1;
                        if (bytes_left == 0) end_xfer(OP_STOP, RES_OK);
                        else issue(OP_SEND, next_payload());
                    end
                XS_R_START:
                    if (status_is_start(st))
                    begin
                        xs = XS_R_ADDR;
                        issue(OP_SEND, {target_addr, 1'b0});
                    end
                    else retry_read(RES_START_FAIL, OP_NONE);
                XS_R_ADDR:
                    if (status_is_ack(st))
                    begin
                        xs = XS_R_REG;
                        issue(OP_SEND, target_reg);
                    end
                    else retry_read(RES_ADDR_NACK, OP_STOP);
                XS_R_REG:
                    if (status_is_ack(st))
                    begin
                        xs = XS_R_RSTART;
                        issue(OP_START, 8'h00);
                    end
                    else end_xfer(OP_NONE, RES_REG_NACK);
                XS_R_RSTART:
                    if (status_is_start(st))
                    begin
                        xs = XS_R_ADDR_RD;
                        issue(OP_SEND, {target_addr, 1'b1});
                    end
                    else end_xfer(OP_NONE, RES_DATA_FAIL);
                XS_R_ADDR_RD:
                    if (!status_is_ack(st)) end_xfer(OP_NONE, RES_RADDR_NACK);
                    else
                    begin
                        xs = XS_R_DATA;
                        issue(receive_op(), 8'h00);
                    end
                XS_R_DATA:
                begin
                    // receive status is not looked at
                    res.read_valid = 1'b1;
                    res.read_data  = rx;
                    res.read_index = byte_pos;
                    byte_pos   = byte_pos + 8'd1;
                    bytes_left = bytes_left - 8'd1;
                    if (bytes_left == 0) end_xfer(OP_STOP, RES_OK);
                    else issue(receive_op(), 8'h00);
                end
                default: ignored = 1'b1;
            endcase
        endfunction

        function void note_input(seq_cmd_t it);
            res     = '0;
            ignored = 1'b0;
            case (it.cmd) inside
                CMD_LOAD: payload[it.buf_index] = it.tx_byte;
                CMD_WRITE, CMD_READ:
                    if (xs != XS_IDLE) ignored = 1'b1;
                    else if (it.length == 0)
                    begin
                        res.done_res    = 1'b1;
                        res.result_code = RES_OK;
                    end
                    else
                    begin
                        target_addr  = it.device_addr;
                        target_reg   = it.reg_addr;
                        bytes_left   = it.length;
                        byte_pos     = 8'd0;
                        retries_left = budget;
                        if (it.cmd == CMD_READ) xs = XS_R_START;
                        else xs = XS_W_START;
                        issue(OP_START, 8'h00);
                    end
                default: bus_done(it.bus_status, it.rx_byte);
            endcase
            expected_q.push_back(res);
        endfunction

        function void compare_field(string name, logic [7:0] want, logic [7:0] got);
            if (got !== want)
            begin
                $display("%0t: %s expected %0d got %0d", $time, name, want, got);
                errors++;
            end
        endfunction

        function void check_result(seq_result_t got);
            seq_result_t want;
            if (expected_q.size() == 0)
            begin
                $display("%0t: result item with nothing expected, bus_op %0d",
                         $time, got.bus_op);
                errors++;
                return;
            end
            want = expected_q.pop_front();
            compare_field("bus_op", 8'(want.bus_op), 8'(got.bus_op));
            compare_field("op_byte", want.op_byte, got.op_byte);
            compare_field("read_valid", 8'(want.read_valid), 8'(got.read_valid));
            compare_field("read_data", want.read_data, got.read_data);
            compare_field("read_index", want.read_index, got.read_index);
            compare_field("done_res", 8'(want.done_res), 8'(got.done_res));
            compare_field("result_code", 8'(want.result_code), 8'(got.result_code));
        endfunction
    endclass

    logic       clk;
    logic       rst_n;
    logic       cfg_we;
    logic [7:0] cfg_wdata;

    rts_in_if  req_if ();
    rts_out_if rsp_if ();

    i2c_register_transfer_sequencer_unit u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req_if),
        .rsp       (rsp_if),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    xfer_scoreboard sb = new();

    bit loaded [PAYLOAD_DEPTH];
    int burst_left = 0;
    int n_items    = 0;
    int quiet      = 0;
    int rx_cyc     = 0;
    int rx_mode    = 0;

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // receiver stall pattern, switching at random among three styles
    always @(negedge clk)
    begin
        rx_cyc++;
        if (rx_cyc % 100 == 0) rx_mode = $urandom_range(0, 2);
        case (rx_mode)
            0:       rsp_if.ready = 1'b1;
            1:       rsp_if.ready = ($urandom_range(0, 3) != 0);
            default: rsp_if.ready = ((rx_cyc % 5) < 3);
        endcase
    end

    // result monitor and activity count
    always @(posedge clk)
    begin
        seq_result_t got;
        if (rst_n && rsp_if.valid && rsp_if.ready)
        begin
            got.bus_op      = bus_op_t'(rsp_if.bus_op);
            got.op_byte     = rsp_if.op_byte;
            got.read_valid  = rsp_if.read_valid;
            got.read_data   = rsp_if.read_data;
            got.read_index  = rsp_if.read_index;
            got.done_res    = rsp_if.done_res;
            got.result_code = res_code_t'(rsp_if.result_code);
            sb.check_result(got);
        end
        if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) quiet = 0;
        else quiet++;
    end

    // watchdog
    initial
    begin
        while (quiet < WATCHDOG_LIMIT) @(posedge clk);
        $display("i2c_register_transfer_sequencer_unit_test: done, errors");
        $finish;
    end

    function automatic seq_cmd_t rand_item();
        seq_cmd_t it;
        it.cmd         = cmd_t'($urandom_range(0, 3));
        it.device_addr = 7'($urandom);
        it.reg_addr    = 8'($urandom);
        it.length      = 8'($urandom);
        it.buf_index   = 8'($urandom);
        it.tx_byte     = 8'($urandom);
        it.bus_status  = 8'($urandom);
        it.rx_byte     = 8'($urandom);
        return it;
    endfunction

    function automatic seq_cmd_t mk_load(logic [7:0] idx, logic [7:0] b);
        seq_cmd_t it;
        it           = rand_item();
        it.cmd       = CMD_LOAD;
        it.buf_index = idx;
        it.tx_byte   = b;
        return it;
    endfunction

    function automatic seq_cmd_t mk_begin(cmd_t c, logic [6:0] a, logic [7:0] r,
                                          logic [7:0] len);
        seq_cmd_t it;
        it             = rand_item();
        it.cmd         = c;
        it.device_addr = a;
        it.reg_addr    = r;
        it.length      = len;
        return it;
    endfunction

    function automatic seq_cmd_t mk_finish(logic [7:0] st, logic [7:0] rx);
        seq_cmd_t it;
        it            = rand_item();
        it.cmd        = CMD_FINISH;
        it.bus_status = st;
        it.rx_byte    = rx;
        return it;
    endfunction

    function automatic int loaded_prefix();
        int n;
        n = 0;
        while (n < PAYLOAD_DEPTH && loaded[8'(n)]) n++;
        return n;
    endfunction

    // anything at all, but a write never reaches past the loaded payload
    function automatic seq_cmd_t noise_item();
        seq_cmd_t it;
        int lim;
        it = rand_item();
        if (sb.xs == XS_IDLE && (it.cmd == CMD_WRITE || it.cmd == CMD_READ))
        begin
            it.length = 8'($urandom_range(0, 7));
            lim = loaded_prefix();
            if (it.cmd == CMD_WRITE && it.length > lim) it.length = 8'(lim);
        end
        return it;
    endfunction

    // bus engine answer for the operation now in flight
    function automatic logic [7:0] pick_status(int fail_pct);
        logic [7:0] s;
        bit want_start;
        bit good;
        want_start = sb.xs inside {XS_W_START, XS_R_START, XS_R_RSTART};
        good = ($urandom_range(0, 99) >= fail_pct);
        if (good)
        begin
            if (want_start) s = START_CODES[1'($urandom_range(0, 1))];
            else s = ACK_CODES[2'($urandom_range(0, 3))];
            s[2:0] = 3'($urandom);
        end
        else
        begin
            do s = 8'($urandom);
            while (want_start ? sb.status_is_start(s) : sb.status_is_ack(s));
        end
        return s;
    endfunction

    // enter and leave at a falling edge; gaps only at burst boundaries
    task automatic push_item(seq_cmd_t it);
        if (burst_left == 0)
        begin
            if ($urandom_range(0, 2) != 0)
            begin
                req_if.valid = 1'b0;
                repeat ($urandom_range(1, 6)) @(negedge clk);
            end
            burst_left = $urandom_range(1, 30);
        end
        req_if.cmd         = it.cmd;
        req_if.device_addr = it.device_addr;
        req_if.reg_addr    = it.reg_addr;
        req_if.length      = it.length;
        req_if.buf_index   = it.buf_index;
        req_if.tx_byte     = it.tx_byte;
        req_if.bus_status  = it.bus_status;
        req_if.rx_byte     = it.rx_byte;
        req_if.valid       = 1'b1;
        do @(posedge clk);
        while (!req_if.ready);
        sb.note_input(it);
        if (it.cmd == CMD_LOAD) loaded[it.buf_index] = 1'b1;
        if (!sb.ignored) n_items++;
        burst_left--;
        @(negedge clk);
    endtask

    // hold off the sender until every expected item has come back
    task automatic drain_results();
        req_if.valid = 1'b0;
        burst_left   = 0;
        while (sb.pending() != 0) @(negedge clk);
        repeat (LATENCY_PAUSE) @(negedge clk);
    endtask

    task automatic set_budget(logic [7:0] v);
        drain_results();
        cfg_we    = 1'b1;
        cfg_wdata = v;
        @(negedge clk);
        cfg_we    = 1'b0;
        sb.budget = v;
    endtask

    task automatic close_xfer();
        while (sb.xs != XS_IDLE) push_item(mk_finish(pick_status(0), 8'($urandom)));
    endtask

    // one well-formed transfer with some stray items mixed in
    task automatic run_transfer(bit rd, int len, int fail_pct);
        if (!rd)
        begin
            for (int p = 0; p < len; p++)
            begin
                if (!loaded[8'(p)] || $urandom_range(0, 3) == 0)
                    push_item(mk_load(8'(p), 8'($urandom)));
            end
        end
        push_item(mk_begin(rd ? CMD_READ : CMD_WRITE, 7'($urandom), 8'($urandom), 8'(len)));
        while (sb.xs != XS_IDLE)
        begin
            if ($urandom_range(0, 29) == 0) push_item(noise_item());
            else push_item(mk_finish(pick_status(fail_pct), 8'($urandom)));
        end
    endtask

    task automatic run_phase(int budget, int fail_pct);
        int target;
        int len;
        target = n_items + budget;
        while (n_items < target)
        begin
            if ($urandom_range(0, 99) < 8)
            begin
                push_item(noise_item());
            end
            else
            begin
                if ($urandom_range(0, 79) == 0) len = $urandom_range(7, 255);
                else len = $urandom_range(0, 6);
                run_transfer(1'($urandom_range(0, 1)), len, fail_pct);
            end
        end
        close_xfer();
    endtask

    // main sequence
    initial
    begin
        rst_n              = 1'b0;
        cfg_we             = 1'b0;
        cfg_wdata          = 8'h00;
        req_if.valid       = 1'b0;
        req_if.cmd         = CMD_LOAD;
        req_if.device_addr = '0;
        req_if.reg_addr    = '0;
        req_if.length      = '0;
        req_if.buf_index   = '0;
        req_if.tx_byte     = '0;
        req_if.bus_status  = '0;
        req_if.rx_byte     = '0;
        rsp_if.ready       = 1'b0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // finish while idle, zero length begins, edge payload entries
        push_item(mk_finish(8'hFF, 8'hFF));
        push_item(mk_begin(CMD_WRITE, 7'h7F, 8'hFF, 8'd0));
        push_item(mk_begin(CMD_READ, 7'h00, 8'h00, 8'd0));
        push_item(mk_load(8'd0, 8'h00));
        push_item(mk_load(8'd1, 8'hFF));
        push_item(mk_load(8'd255, 8'h5A));

        // full two byte write, status low bits set, begin while busy
        push_item(mk_begin(CMD_WRITE, 7'h7F, 8'h00, 8'd2));
        push_item(mk_finish(8'h0F, 8'h00));
        push_item(mk_begin(CMD_READ, 7'h12, 8'h34, 8'd3));
        push_item(mk_finish(8'h18, 8'h00));
        push_item(mk_finish(8'h28, 8'h00));
        push_item(mk_finish(8'h57, 8'h00));
        push_item(mk_finish(8'h40, 8'h00));

        // single byte read through the repeated start
        push_item(mk_begin(CMD_READ, 7'h00, 8'hFF, 8'd1));
        push_item(mk_finish(8'h10, 8'h00));
        push_item(mk_finish(8'h18, 8'h00));
        push_item(mk_finish(8'h28, 8'h00));
        push_item(mk_finish(8'h10, 8'h00));
        push_item(mk_finish(8'h40, 8'h00));
        push_item(mk_finish(8'h00, 8'hFF));

        // longest write cut short by a register nack
        push_item(mk_begin(CMD_WRITE, 7'h55, 8'h80, 8'd255));
        push_item(mk_finish(8'h08, 8'h00));
        push_item(mk_finish(8'h18, 8'h00));
        push_item(mk_finish(8'h20, 8'h00));

        // zero budget: a read keeps restarting for 256 failed starts
        set_budget(8'd0);
        run_transfer(1'b1, 3, 100);
        run_phase(40, 25);

        set_budget(8'd1);
        run_phase(70, 30);

        set_budget(8'd255);
        run_phase(70, 10);

        set_budget(8'($urandom_range(2, 6)));
        run_phase(80, 15);

        set_budget(8'd3);
        run_phase(80, 20);

        set_budget(RESTARTS_RESET);
        run_phase(80, 5);

        drain_results();
        if (sb.errors == 0)
            $display("i2c_register_transfer_sequencer_unit_test: done, clean");
        else
            $display("i2c_register_transfer_sequencer_unit_test: done, errors");
        $finish;
    end
endmodule

// ===== i2c_register_transfer_sequencer_unit.f =====
rtl/core/rts_pkg.sv
rtl/core/rts_if.sv
rtl/core/rts_payload_mem.sv
rtl/core/rts_ctrl.sv
rtl/core/rts_out.sv
rtl/core/i2c_register_transfer_sequencer_unit.sv
rtl/core/rts_chk.sv
test/i2c_register_transfer_sequencer_unit_test.sv
